### sv/hcp_pkg.sv
package hcp_pkg;

   // Table geometry. The home slot is taken from the low key bits, so SLOTS is kept
   // a power of two.
   localparam int SLOTS    = 16;
   localparam int KEY_BITS = 40;
   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int USED_W   = $clog2(SLOTS + 1);

   // Field widths of the two channels.
   localparam int ENTRY_KEY_W  = 40;
   localparam int ID_W         = 32;
   localparam int NAME_W       = 64;
   localparam int SLOT_INDEX_W = 4;

   localparam int REQ_DATA_W  = ENTRY_KEY_W + ID_W + NAME_W;
   localparam int REQ_TDATA_W = ((REQ_DATA_W + 7) / 8) * 8;
   localparam int RSP_DATA_W  = SLOT_INDEX_W + ID_W + NAME_W;
   localparam int RSP_TDATA_W = ((RSP_DATA_W + 7) / 8) * 8;

   typedef enum logic [0:0] {
      REQ_INSERT = 1'b0,
      REQ_SEARCH = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_FOUND     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [ID_W-1:0]     id;
      logic [NAME_W-1:0]   name;
   } record_type;

   localparam int REC_W = $bits(record_type);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_SRCH_CMP,
      S_SRCH_WAIT,
      S_INS_CHECK,
      S_CHAIN_STEP,
      S_CHAIN_WAIT,
      S_CHAIN_END,
      S_APP_PROBE,
      S_REPL_PROBE,
      S_REPL_WAIT,
      S_REPL_STEP,
      S_FINISH
   } fsm_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,       // latch the request, pointer to home slot
      OP_PUT_HOME,     // write the new record into an empty home slot
      OP_SAVE_REPLACE, // keep the resident, write the newcomer at home
      OP_FOLLOW,       // pointer follows the link just read
      OP_PROBE_INIT,   // probe starts at the slot after the pointer
      OP_PROBE_NEXT,   // probe moves on by one slot
      OP_APPEND,       // new record at the probe slot, linked from the pointer
      OP_MOVE_RES,     // resident to the probe slot, walk from its home
      OP_RELINK        // predecessor link now points at the probe slot
   } dp_op_type;

   typedef enum logic [2:0] {
      RK_NOT_FOUND,
      RK_FULL,
      RK_FOUND,
      RK_INS_HOME,
      RK_INS_PRB
   } res_kind_type;

   typedef struct packed {
      dp_op_type    op;
      logic         res_load;
      res_kind_type res_kind;
      logic         out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic key_zero;
      logic is_search;
      logic table_full;
      logic occ_ptr;
      logic occ_prb;
      logic home_differs;
      logic key_match;
      logic lv_ptr;
      logic link_to_home;
      logic cnt_last;
   } dp_status_type;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
   endfunction

endpackage

### sv/hcp_ram.sv
module hcp_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/hcp_dpath.sv
module hcp_dpath import hcp_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  ctrl_cmd_type            cmd,
   output dp_status_type           stat,
   input  req_kind_type            req_kind,
   input  logic [ENTRY_KEY_W-1:0]  entry_key,
   input  logic [ID_W-1:0]         entry_id,
   input  logic [NAME_W-1:0]       entry_name,
   output status_type              out_status,
   output logic [SLOT_INDEX_W-1:0] out_slot,
   output logic [ID_W-1:0]         out_id,
   output logic [NAME_W-1:0]       out_name
);

   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [ID_W-1:0]         id_ff, id_in;
   logic [NAME_W-1:0]       name_ff, name_in;
   logic                    search_ff, search_in;
   logic [SLOT_W-1:0]       home_ff, home_in;
   logic [SLOT_W-1:0]       ptr_ff, ptr_in;
   logic [SLOT_W-1:0]       prb_ff, prb_in;
   logic [SLOT_W-1:0]       cnt_ff, cnt_in;
   record_type              res_rec_ff, res_rec_in;
   logic [SLOT_W-1:0]       res_link_ff, res_link_in;
   logic                    res_lv_ff, res_lv_in;
   logic [SLOTS-1:0]        occ_ff, occ_in;
   logic [SLOTS-1:0]        lv_ff, lv_in;
   logic [USED_W-1:0]       used_ff, used_in;
   status_type              st_ff, st_in;
   logic [SLOT_INDEX_W-1:0] slot_ff, slot_in;
   logic [ID_W-1:0]         fid_ff, fid_in;
   logic [NAME_W-1:0]       fname_ff, fname_in;
   status_type              ost_ff, ost_in;
   logic [SLOT_INDEX_W-1:0] oslot_ff, oslot_in;
   logic [ID_W-1:0]         oid_ff, oid_in;
   logic [NAME_W-1:0]       oname_ff, oname_in;

   logic                    rec_we;
   logic [SLOT_W-1:0]       rec_waddr;
   record_type              rec_wdata;
   record_type              rec_rdata;
   logic                    link_we;
   logic [SLOT_W-1:0]       link_waddr;
   logic [SLOT_W-1:0]       link_wdata;
   logic [SLOT_W-1:0]       link_rdata;
   logic [KEY_BITS-1:0]     key_lo;

   assign key_lo = entry_key[KEY_BITS-1:0];

   // Both stores are read at the walk pointer every cycle; the read data is registered.
   hcp_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_rec_ram (
      .clock (clock),
      .we    (rec_we),
      .waddr (rec_waddr),
      .wdata (rec_wdata),
      .raddr (ptr_ff),
      .rdata (rec_rdata)
   );

   hcp_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .raddr (ptr_ff),
      .rdata (link_rdata)
   );

   always_comb begin
      key_in      = key_ff;
      id_in       = id_ff;
      name_in     = name_ff;
      search_in   = search_ff;
      home_in     = home_ff;
      ptr_in      = ptr_ff;
      prb_in      = prb_ff;
      cnt_in      = cnt_ff;
      res_rec_in  = res_rec_ff;
      res_link_in = res_link_ff;
      res_lv_in   = res_lv_ff;
      occ_in      = occ_ff;
      lv_in       = lv_ff;
      used_in     = used_ff;
      rec_we      = 1'b0;
      rec_waddr   = ptr_ff;
      rec_wdata   = '{key: key_ff, id: id_ff, name: name_ff};
      link_we     = 1'b0;
      link_waddr  = ptr_ff;
      link_wdata  = prb_ff;

      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_ACCEPT: begin
            key_in    = key_lo;
            id_in     = entry_id;
            name_in   = entry_name;
            search_in = (req_kind == REQ_SEARCH);
            home_in   = key_lo[SLOT_W-1:0];
            ptr_in    = key_lo[SLOT_W-1:0];
            cnt_in    = '0;
         end
         OP_PUT_HOME: begin
            rec_we         = 1'b1;
            occ_in[ptr_ff] = 1'b1;
            lv_in[ptr_ff]  = 1'b0;
         end
         OP_SAVE_REPLACE: begin
            res_rec_in    = rec_rdata;
            res_link_in   = link_rdata;
            res_lv_in     = lv_ff[ptr_ff];
            rec_we        = 1'b1;
            lv_in[ptr_ff] = 1'b0;
            prb_in        = next_slot(ptr_ff);
         end
         OP_FOLLOW: begin
            ptr_in = link_rdata;
            cnt_in = cnt_ff + 1'b1;
         end
         OP_PROBE_INIT: begin
            prb_in = next_slot(ptr_ff);
         end
         OP_PROBE_NEXT: begin
            prb_in = next_slot(prb_ff);
         end
         OP_APPEND: begin
            rec_we         = 1'b1;
            rec_waddr      = prb_ff;
            occ_in[prb_ff] = 1'b1;
            lv_in[prb_ff]  = 1'b0;
            link_we        = 1'b1;
            lv_in[ptr_ff]  = 1'b1;
         end
         OP_MOVE_RES: begin
            rec_we         = 1'b1;
            rec_waddr      = prb_ff;
            rec_wdata      = res_rec_ff;
            link_we        = 1'b1;
            link_waddr     = prb_ff;
            link_wdata     = res_link_ff;
            lv_in[prb_ff]  = res_lv_ff;
            occ_in[prb_ff] = 1'b1;
            ptr_in         = res_rec_ff.key[SLOT_W-1:0];
            cnt_in         = '0;
         end
         OP_RELINK: begin
            link_we = 1'b1;
         end
         default: begin
         end
      endcase

      st_in    = st_ff;
      slot_in  = slot_ff;
      fid_in   = fid_ff;
      fname_in = fname_ff;
      if (cmd.res_load) begin
         slot_in  = '0;
         fid_in   = '0;
         fname_in = '0;
         case (cmd.res_kind)
            RK_FULL: begin
               st_in = ST_FULL;
            end
            RK_FOUND: begin
               st_in    = ST_FOUND;
               slot_in  = SLOT_INDEX_W'(ptr_ff);
               fid_in   = rec_rdata.id;
               fname_in = rec_rdata.name;
            end
            RK_INS_HOME: begin
               st_in   = ST_INSERTED;
               slot_in = SLOT_INDEX_W'(home_ff);
               used_in = used_ff + 1'b1;
            end
            RK_INS_PRB: begin
               st_in   = ST_INSERTED;
               slot_in = SLOT_INDEX_W'(prb_ff);
               used_in = used_ff + 1'b1;
            end
            default: begin
               st_in = ST_NOT_FOUND;
            end
         endcase
      end

      ost_in   = ost_ff;
      oslot_in = oslot_ff;
      oid_in   = oid_ff;
      oname_in = oname_ff;
      if (cmd.out_load) begin
         ost_in   = st_ff;
         oslot_in = slot_ff;
         oid_in   = fid_ff;
         oname_in = fname_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff  <= '0;
         lv_ff   <= '0;
         used_ff <= '0;
      end else begin
         occ_ff  <= occ_in;
         lv_ff   <= lv_in;
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      id_ff       <= id_in;
      name_ff     <= name_in;
      search_ff   <= search_in;
      home_ff     <= home_in;
      ptr_ff      <= ptr_in;
      prb_ff      <= prb_in;
      cnt_ff      <= cnt_in;
      res_rec_ff  <= res_rec_in;
      res_link_ff <= res_link_in;
      res_lv_ff   <= res_lv_in;
      st_ff       <= st_in;
      slot_ff     <= slot_in;
      fid_ff      <= fid_in;
      fname_ff    <= fname_in;
      ost_ff      <= ost_in;
      oslot_ff    <= oslot_in;
      oid_ff      <= oid_in;
      oname_ff    <= oname_in;
   end

   always_comb begin
      stat.key_zero     = (key_ff == '0);
      stat.is_search    = search_ff;
      stat.table_full   = (used_ff >= USED_W'(SLOTS));
      stat.occ_ptr      = occ_ff[ptr_ff];
      stat.occ_prb      = occ_ff[prb_ff];
      stat.home_differs = (rec_rdata.key[SLOT_W-1:0] != home_ff);
      stat.key_match    = occ_ff[ptr_ff] && (rec_rdata.key == key_ff);
      stat.lv_ptr       = lv_ff[ptr_ff];
      stat.link_to_home = (link_rdata == home_ff);
      stat.cnt_last     = (cnt_ff == SLOT_W'(SLOTS - 1));
   end

   assign out_status = ost_ff;
   assign out_slot   = oslot_ff;
   assign out_id     = oid_ff;
   assign out_name   = oname_ff;

endmodule

### sv/hcp_ctrl.sv
module hcp_ctrl import hcp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type stat,
   output ctrl_cmd_type  cmd
);

   fsm_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '{op: OP_NONE, res_load: 1'b0, res_kind: RK_NOT_FOUND, out_load: 1'b0};

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_ACCEPT;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.key_zero) begin
               cmd.res_load = 1'b1;
               cmd.res_kind = RK_NOT_FOUND;
               state_in     = S_FINISH;
            end else if (stat.is_search) begin
               state_in = S_SRCH_CMP;
            end else if (stat.table_full) begin
               cmd.res_load = 1'b1;
               cmd.res_kind = RK_FULL;
               state_in     = S_FINISH;
            end else if (!stat.occ_ptr) begin
               cmd.op       = OP_PUT_HOME;
               cmd.res_load = 1'b1;
               cmd.res_kind = RK_INS_HOME;
               state_in     = S_FINISH;
            end else begin
               state_in = S_INS_CHECK;
            end
         end
         S_SRCH_CMP: begin
            if (stat.key_match) begin
               cmd.res_load = 1'b1;
               cmd.res_kind = RK_FOUND;
               state_in     = S_FINISH;
            end else if (!stat.lv_ptr || stat.cnt_last) begin
               cmd.res_load = 1'b1;
               cmd.res_kind = RK_NOT_FOUND;
               state_in     = S_FINISH;
            end else begin
               cmd.op   = OP_FOLLOW;
               state_in = S_SRCH_WAIT;
            end
         end
         S_SRCH_WAIT: begin
            state_in = S_SRCH_CMP;
         end
         S_INS_CHECK: begin
            if (stat.home_differs) begin
               cmd.op   = OP_SAVE_REPLACE;
               state_in = S_REPL_PROBE;
            end else begin
               state_in = S_CHAIN_STEP;
            end
         end
         S_CHAIN_STEP: begin
            if (!stat.lv_ptr) begin
               cmd.op   = OP_PROBE_INIT;
               state_in = S_APP_PROBE;
            end else if (stat.cnt_last) begin
               cmd.op   = OP_FOLLOW;
               state_in = S_CHAIN_END;
            end else begin
               cmd.op   = OP_FOLLOW;
               state_in = S_CHAIN_WAIT;
            end
         end
         S_CHAIN_WAIT: begin
            state_in = S_CHAIN_STEP;
         end
         S_CHAIN_END: begin
            cmd.op   = OP_PROBE_INIT;
            state_in = S_APP_PROBE;
         end
         S_APP_PROBE: begin
            if (!stat.occ_prb) begin
               cmd.op       = OP_APPEND;
               cmd.res_load = 1'b1;
               cmd.res_kind = RK_INS_PRB;
               state_in     = S_FINISH;
            end else begin
               cmd.op = OP_PROBE_NEXT;
            end
         end
         S_REPL_PROBE: begin
            if (!stat.occ_prb) begin
               cmd.op   = OP_MOVE_RES;
               state_in = S_REPL_WAIT;
            end else begin
               cmd.op = OP_PROBE_NEXT;
            end
         end
         S_REPL_WAIT: begin
            state_in = S_REPL_STEP;
         end
         S_REPL_STEP: begin
            if (stat.lv_ptr && stat.link_to_home) begin
               cmd.op       = OP_RELINK;
               cmd.res_load = 1'b1;
               cmd.res_kind = RK_INS_HOME;
               state_in     = S_FINISH;
            end else if (!stat.lv_ptr || stat.cnt_last) begin
               cmd.res_load = 1'b1;
               cmd.res_kind = RK_INS_HOME;
               state_in     = S_FINISH;
            end else begin
               cmd.op   = OP_FOLLOW;
               state_in = S_REPL_WAIT;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

### sv/hash_chain_probe_with_replace.sv
// Channel  Direction  tuser                  tdata (lowest bit first)
// req      in         req_type (1 bit)       entry_key 40, entry_id 32, entry_name 64
// rsp      out        status (2 bits)        slot_index 4, found_id 32, found_name 64, 4 zero
//
// One request is worked on at a time. Each store has one registered-read port, so a chain
// step passes through a wait state for the read data; free-slot probes check one slot per
// cycle from the occupancy flops. The block returns to idle after each item before it takes
// the next request. Synchronous reset clears the occupancy and link valid flops, so no
// clearing pass is needed. A finished result waits in the output register while the next
// request is taken; a stalled rsp side holds the block in its final state.
module hash_chain_probe_with_replace import hcp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // entry_key [39:0], entry_id [71:40], entry_name [135:72]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type [0]
   input  logic [0:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // slot_index [3:0], found_id [35:4], found_name [99:36], zero fill [103:100]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // status [1:0]
   output logic [1:0]             rsp_tuser
);

   ctrl_cmd_type            cmd;
   dp_status_type           stat;
   status_type              out_status;
   logic [SLOT_INDEX_W-1:0] out_slot;
   logic [ID_W-1:0]         out_id;
   logic [NAME_W-1:0]       out_name;
   req_kind_type            req_kind;

   assign req_kind = req_kind_type'(req_tuser[0]);

   // The controller sequences each request; it sees only the status flags below and
   // drives one datapath command per cycle.
   hcp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // The datapath holds the record and link stores, the walk and probe pointers, the
   // occupancy flops and the result registers.
   hcp_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_kind   (req_kind),
      .entry_key  (req_tdata[ENTRY_KEY_W-1:0]),
      .entry_id   (req_tdata[ENTRY_KEY_W+ID_W-1:ENTRY_KEY_W]),
      .entry_name (req_tdata[REQ_DATA_W-1:ENTRY_KEY_W+ID_W]),
      .out_status (out_status),
      .out_slot   (out_slot),
      .out_id     (out_id),
      .out_name   (out_name)
   );

   // The zero fill in the top four bits comes from the width extension.
   assign rsp_tdata = RSP_TDATA_W'({out_name, out_id, out_slot});
   assign rsp_tuser = out_status;

endmodule

### sv/hcp_checker.sv
module hcp_checker import hcp_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic [0:0]             req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [1:0]             rsp_tuser
);

   // A result waiting on the rsp side must not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transfer changed while stalled");

   // A request occupies the block for at least the cycle after its transfer.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while the previous one is still in work");

   // Only a found record carries an id and a name.
   a_zero_unless_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_FOUND) |->
         rsp_tdata[RSP_DATA_W-1:SLOT_INDEX_W] == '0)
      else $error("id or name present on a result that is not a hit");

   // A full table or a missing record reports slot zero.
   a_slot_zero_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser == ST_FULL) || (rsp_tuser == ST_NOT_FOUND)) |->
         rsp_tdata[SLOT_INDEX_W-1:0] == '0)
      else $error("slot index set on a miss or full result");

endmodule

bind hash_chain_probe_with_replace hcp_checker u_hcp_checker (.*);
